/* sv/g2j_pkg.sv */
// Package for the Gregorian to Jalali BCD date converter.
// Holds the transaction structs, calendar constants and small table functions.
// No dependencies.
package g2j_pkg;

    // Input transaction: Gregorian date inside the 2000s, packed BCD.
    typedef struct packed {
        logic [7:0] year_bcd;
        logic [7:0] month_bcd;
        logic [7:0] day_bcd;
    } t_in_item;

    // Output transaction: Jalali date, packed BCD, plus the reject flag.
    typedef struct packed {
        logic [7:0] jyear_century_bcd;
        logic [7:0] jyear_low_bcd;
        logic [7:0] jmonth_bcd;
        logic [7:0] jday_bcd;
        logic       bad_input;
    } t_out_item;

    // Classified date handed from the front end to the back end.
    typedef struct packed {
        logic [6:0] year_val;
        logic [3:0] month_val;
        logic [4:0] day_val;
        logic       leap;
        logic       bad;
    } t_class;

    localparam int unsigned CYCLE33_DAYS = 12053;
    localparam int unsigned GROUP4_DAYS  = 1461;
    localparam int unsigned YEAR_DAYS    = 365;
    localparam int unsigned JALALI_OFFSET = 79;
    localparam int unsigned JALALI_BASE_YEAR = 979;
    // Days from 1600-01-01 to 2000-01-01.
    localparam int unsigned DAYS_TO_2000 = 146097;
    // The day count always holds at least twelve full 33-year cycles, so they
    // are removed up front; the extra minus one folds in the day-of-month base.
    localparam int unsigned BASE_CYCLES = 12;
    localparam int unsigned DAY_BIAS =
        DAYS_TO_2000 - JALALI_OFFSET - BASE_CYCLES * CYCLE33_DAYS - 1;
    // Jalali year minus 1300 before the cycle, group and year terms are added.
    localparam int unsigned JY_BIAS = JALALI_BASE_YEAR + 33 * BASE_CYCLES - 1300;

    // Length of a Gregorian month, month given 1 to 12.
    function automatic logic [4:0] greg_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in a common Gregorian year before the first of month m.
    function automatic logic [8:0] greg_cum(input logic [3:0] m);
        logic [8:0] c;
        unique case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // Day of the Jalali year on which month index i (0 to 11) begins.
    function automatic logic [8:0] jal_cum(input logic [3:0] i);
        logic [8:0] c;
        unique case (i)
            4'd0:    c = 9'd0;
            4'd1:    c = 9'd31;
            4'd2:    c = 9'd62;
            4'd3:    c = 9'd93;
            4'd4:    c = 9'd124;
            4'd5:    c = 9'd155;
            4'd6:    c = 9'd186;
            4'd7:    c = 9'd216;
            4'd8:    c = 9'd246;
            4'd9:    c = 9'd276;
            4'd10:   c = 9'd306;
            4'd11:   c = 9'd336;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // Two packed BCD digits of a value below 100; v*205>>11 equals v/10 here.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

/* sv/g2j_front.sv */
// Front end of the Gregorian to Jalali converter: accepts a BCD date, checks
// digits, month and day, and registers the binary classified form.
// Depends on g2j_pkg.
module g2j_front import g2j_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_class   o_item
);

    logic   r_valid;
    t_class r_item;
    t_class n_item;

    logic [6:0] yv, mv, dv;
    logic       digits_ok, mon_ok, day_ok, leap;
    logic [4:0] mlen;

    always_comb begin
        digits_ok = (i_in_item.year_bcd[7:4] <= 4'd9) && (i_in_item.year_bcd[3:0] <= 4'd9)
                 && (i_in_item.month_bcd[7:4] <= 4'd9) && (i_in_item.month_bcd[3:0] <= 4'd9)
                 && (i_in_item.day_bcd[7:4] <= 4'd9) && (i_in_item.day_bcd[3:0] <= 4'd9);
        yv = 7'(i_in_item.year_bcd[7:4]) * 7'd10 + 7'(i_in_item.year_bcd[3:0]);
        mv = 7'(i_in_item.month_bcd[7:4]) * 7'd10 + 7'(i_in_item.month_bcd[3:0]);
        dv = 7'(i_in_item.day_bcd[7:4]) * 7'd10 + 7'(i_in_item.day_bcd[3:0]);
        // Within 2000 to 2099 the century rules cancel; 2000 itself is leap.
        leap   = (yv[1:0] == 2'd0);
        mon_ok = (mv >= 7'd1) && (mv <= 7'd12);
        mlen   = greg_len(mv[3:0], leap);
        day_ok = (dv >= 7'd1) && (dv <= 7'(mlen));

        n_item.bad = !(digits_ok && mon_ok && day_ok);
        if (n_item.bad) begin
            n_item.year_val  = '0;
            n_item.month_val = '0;
            n_item.day_val   = '0;
            n_item.leap      = 1'b0;
        end else begin
            n_item.year_val  = yv;
            n_item.month_val = mv[3:0];
            n_item.day_val   = dv[4:0];
            n_item.leap      = leap;
        end
    end

    assign o_in_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* sv/g2j_fifo.sv */
// Short queue of classified dates between the front and back ends.
// Depends on g2j_pkg.
module g2j_fifo import g2j_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_valid,
    output logic   o_wr_ready,
    input  t_class i_wr_item,
    output logic   o_rd_valid,
    input  logic   i_rd_ready,
    output t_class o_rd_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_class             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               wr, rd;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign wr         = i_wr_valid && o_wr_ready;
    assign rd         = o_rd_valid && i_rd_ready;
    assign o_rd_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wr_item;
        end
    end

endmodule

/* sv/g2j_back.sv */
// Back end of the Gregorian to Jalali converter: a five-stage pipeline that
// counts days, splits them into cycles, groups, years and months, and packs BCD.
// Depends on g2j_pkg.
module g2j_back import g2j_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_class    i_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] rdy;

    // Stage payloads.
    logic [15:0] r1_days;
    logic        r1_bad;
    logic [1:0]  r2_q33;
    logic [13:0] r2_rem;
    logic        r2_bad;
    logic [1:0]  r3_q33;
    logic [3:0]  r3_q4;
    logic [10:0] r3_rem;
    logic        r3_bad;
    logic [7:0]  r4_yoff;
    logic [8:0]  r4_doy;
    logic        r4_bad;
    t_out_item   r5_out;

    logic [15:0] n1_days;
    logic [1:0]  n2_q33;
    logic [13:0] n2_rem;
    logic [3:0]  n3_q4;
    logic [13:0] g4_base;
    logic [10:0] n3_rem;
    logic [10:0] yr_t;
    logic [1:0]  yadd;
    logic [8:0]  n4_doy;
    logic [7:0]  n4_yoff;
    logic [3:0]  mon_idx;
    logic [8:0]  mon_base;
    logic [7:0]  low_val;
    logic [7:0]  century;
    t_out_item   n5_out;

    // A stage takes new data when it is empty or its successor moves.
    always_comb begin
        rdy[STAGES-1] = !r_vld[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: days since the Jalali epoch, less twelve 33-year cycles.
    always_comb begin
        n1_days = 16'(DAY_BIAS)
                + 16'(i_item.year_val) * 16'(YEAR_DAYS)
                + 16'((8'(i_item.year_val) + 8'd3) >> 2)
                + 16'(greg_cum(i_item.month_val))
                + 16'(i_item.leap && (i_item.month_val > 4'd2))
                + 16'(i_item.day_val);
    end

    // Stage 2: remaining 33-year cycles, at most three.
    always_comb begin
        priority if (r1_days >= 16'(3 * CYCLE33_DAYS)) begin
            n2_q33 = 2'd3;
            n2_rem = 14'(r1_days - 16'(3 * CYCLE33_DAYS));
        end else if (r1_days >= 16'(2 * CYCLE33_DAYS)) begin
            n2_q33 = 2'd2;
            n2_rem = 14'(r1_days - 16'(2 * CYCLE33_DAYS));
        end else if (r1_days >= 16'(CYCLE33_DAYS)) begin
            n2_q33 = 2'd1;
            n2_rem = 14'(r1_days - 16'(CYCLE33_DAYS));
        end else begin
            n2_q33 = 2'd0;
            n2_rem = r1_days[13:0];
        end
    end

    // Stage 3: 4-year groups inside the cycle, found by parallel compares.
    always_comb begin
        n3_q4   = 4'd0;
        g4_base = 14'd0;
        for (int k = 1; k <= 8; k++) begin
            if (r2_rem >= 14'(k * GROUP4_DAYS)) begin
                n3_q4   = 4'(k);
                g4_base = 14'(k * GROUP4_DAYS);
            end
        end
        n3_rem = 11'(r2_rem - g4_base);
    end

    // Stage 4: year inside the group (the first year has 366 days) and the
    // Jalali year offset from 1300.
    always_comb begin
        yr_t = r3_rem - 11'd1;
        if (r3_rem >= 11'd366) begin
            priority if (yr_t >= 11'(3 * YEAR_DAYS)) begin
                yadd   = 2'd3;
                n4_doy = 9'(yr_t - 11'(3 * YEAR_DAYS));
            end else if (yr_t >= 11'(2 * YEAR_DAYS)) begin
                yadd   = 2'd2;
                n4_doy = 9'(yr_t - 11'(2 * YEAR_DAYS));
            end else begin
                yadd   = 2'd1;
                n4_doy = 9'(yr_t - 11'(YEAR_DAYS));
            end
        end else begin
            yadd   = 2'd0;
            n4_doy = r3_rem[8:0];
        end
        n4_yoff = 8'(JY_BIAS) + 8'(r3_q33) * 8'd33 + {2'b00, r3_q4, 2'b00} + 8'(yadd);
    end

    // Stage 5: month search, century split and BCD packing.
    always_comb begin
        mon_idx  = 4'd0;
        mon_base = 9'd0;
        for (int i = 1; i < 12; i++) begin
            if (r4_doy >= jal_cum(4'(i))) begin
                mon_idx  = 4'(i);
                mon_base = jal_cum(4'(i));
            end
        end
        priority if (r4_yoff >= 8'd200) begin
            century = 8'd15;
            low_val = r4_yoff - 8'd200;
        end else if (r4_yoff >= 8'd100) begin
            century = 8'd14;
            low_val = r4_yoff - 8'd100;
        end else begin
            century = 8'd13;
            low_val = r4_yoff;
        end
        if (r4_bad) begin
            n5_out           = '0;
            n5_out.bad_input = 1'b1;
        end else begin
            n5_out.jyear_century_bcd = to_bcd(century[6:0]);
            n5_out.jyear_low_bcd     = to_bcd(low_val[6:0]);
            n5_out.jmonth_bcd        = to_bcd(7'(mon_idx) + 7'd1);
            n5_out.jday_bcd          = to_bcd(7'(r4_doy - mon_base) + 7'd1);
            n5_out.bad_input         = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r1_days <= n1_days;
            r1_bad  <= i_item.bad;
        end
        if (rdy[1] && r_vld[0]) begin
            r2_q33 <= n2_q33;
            r2_rem <= n2_rem;
            r2_bad <= r1_bad;
        end
        if (rdy[2] && r_vld[1]) begin
            r3_q33 <= r2_q33;
            r3_q4  <= n3_q4;
            r3_rem <= n3_rem;
            r3_bad <= r2_bad;
        end
        if (rdy[3] && r_vld[2]) begin
            r4_yoff <= n4_yoff;
            r4_doy  <= n4_doy;
            r4_bad  <= r3_bad;
        end
        if (rdy[4] && r_vld[3]) begin
            r5_out <= n5_out;
        end
    end

    assign o_out_valid = r_vld[STAGES-1];
    assign o_out_item  = r5_out;

endmodule

/* sv/gregorian_to_jalali_bcd_unit.sv */
// Top level of the Gregorian to Jalali BCD date converter: front end, queue,
// back-end pipeline. Depends on g2j_pkg, g2j_front, g2j_fifo and g2j_back.
//
//  Channel  Valid         Ready         Payload      Direction
//  input    i_in_valid    o_in_ready    i_in_item    Gregorian date in
//  output   o_out_valid   i_out_ready   o_out_item   Jalali date out
//
// One transaction per clock is sustained while the output is not stalled;
// the back end is a five-stage pipeline, entered through the front register
// and the queue.
// i_rst_n is synchronous and active low; it empties every stage and the queue.
// A stall on the output fills the back end, then the queue, then the front.
module gregorian_to_jalali_bcd_unit import g2j_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic   front_valid, front_ready;
    t_class front_item;
    logic   queue_valid, queue_ready;
    t_class queue_item;

    g2j_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_valid    (front_valid),
        .i_ready    (front_ready),
        .o_item     (front_item)
    );

    g2j_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_item  (front_item),
        .o_rd_valid (queue_valid),
        .i_rd_ready (queue_ready),
        .o_rd_item  (queue_item)
    );

    g2j_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .o_ready     (queue_ready),
        .i_item      (queue_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* sv/g2j_checker.sv */
// Port-level checker for the Gregorian to Jalali converter, bound to the top.
// Depends on g2j_pkg and gregorian_to_jalali_bcd_unit.
module g2j_checker import g2j_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // Reset leaves no transaction on the output.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A rejected date carries an all-zero Jalali date.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.bad_input) |->
        (o_out_item.jyear_century_bcd == 8'h00 && o_out_item.jyear_low_bcd == 8'h00
         && o_out_item.jmonth_bcd == 8'h00 && o_out_item.jday_bcd == 8'h00))
        else $error("bad input with nonzero date");

    // A good date lands in the Jalali 1300s or 1400s with a nonzero month and day.
    a_good_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.bad_input) |->
        ((o_out_item.jyear_century_bcd == 8'h13 || o_out_item.jyear_century_bcd == 8'h14)
         && o_out_item.jmonth_bcd != 8'h00 && o_out_item.jday_bcd != 8'h00))
        else $error("Jalali date out of range");

    // A stalled output transaction holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("output changed while stalled");

    // A waiting input transaction holds until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_item)))
        else $error("input changed while waiting");

endmodule

bind gregorian_to_jalali_bcd_unit g2j_checker u_g2j_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

/* sim/tb_gregorian_to_jalali_bcd_unit.sv */
// Testbench for gregorian_to_jalali_bcd_unit: drives Gregorian BCD dates and checks the
// Jalali BCD dates and reject flags against a behavioral calendar predictor.
// Depends on g2j_pkg and the RTL of the converter.
module tb_gregorian_to_jalali_bcd_unit import g2j_pkg::*; ;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_DATES  = 1330;
    localparam int unsigned NOWRUZ_SHIFT  = 79;
    localparam int unsigned CYCLE_DAYS    = 12053;
    localparam int unsigned QUAD_DAYS     = 1461;
    localparam int unsigned COMMON_DAYS   = 365;
    localparam int unsigned FIRST_JYEAR   = 979;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    t_out_item   jalali_due[$];
    int unsigned mismatches  = 0;
    int unsigned quiet_count = 0;
    bit          steady_phase = 1'b0;

    gregorian_to_jalali_bcd_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [7:0] to_packed_bcd(input int unsigned v);
        return {4'((v / 10) % 10), 4'(v % 10)};
    endfunction

    function automatic int unsigned bcd_value(input logic [7:0] b);
        return b[7:4] * 10 + b[3:0];
    endfunction

    function automatic bit bcd_digits_ok(input logic [7:0] b);
        return (b[7:4] <= 9) && (b[3:0] <= 9);
    endfunction

    // Leap rule applied to the year 20yy.
    function automatic bit leap_20yy(input int unsigned yy);
        int unsigned y;
        y = 2000 + yy;
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned greg_month_len(input int unsigned m, input bit leap);
        if (m == 2)
            return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic int unsigned jalali_month_len(input int unsigned k);
        if (k < 6)
            return 31;
        if (k < 11)
            return 30;
        return 29;
    endfunction

    function automatic t_out_item jalali_of(input t_in_item g);
        t_out_item   r;
        int unsigned yy, mm, dd, span, days, jy, k;
        bit          leap;
        r = '0;
        if (!bcd_digits_ok(g.year_bcd) || !bcd_digits_ok(g.month_bcd) ||
            !bcd_digits_ok(g.day_bcd)) begin
            r.bad_input = 1'b1;
            return r;
        end
        yy   = bcd_value(g.year_bcd);
        mm   = bcd_value(g.month_bcd);
        dd   = bcd_value(g.day_bcd);
        leap = leap_20yy(yy);
        if (mm < 1 || mm > 12 || dd < 1 || dd > greg_month_len(mm, leap)) begin
            r.bad_input = 1'b1;
            return r;
        end
        // Day count from 1600-01-01, then moved to the Jalali epoch.
        span = 400 + yy;
        days = COMMON_DAYS * span + (span + 3) / 4 - (span + 99) / 100 + (span + 399) / 400;
        for (k = 1; k < mm; k++)
            days += greg_month_len(k, leap);
        days = days + dd - 1 - NOWRUZ_SHIFT;
        jy   = FIRST_JYEAR + 33 * (days / CYCLE_DAYS);
        days = days % CYCLE_DAYS;
        jy   += 4 * (days / QUAD_DAYS);
        days = days % QUAD_DAYS;
        // The first year of each four-year group is the long one.
        if (days >= 366) begin
            jy   += (days - 1) / COMMON_DAYS;
            days = (days - 1) % COMMON_DAYS;
        end
        k = 0;
        while (k < 11 && days >= jalali_month_len(k)) begin
            days -= jalali_month_len(k);
            k++;
        end
        r.jyear_century_bcd = to_packed_bcd((jy / 100) % 100);
        r.jyear_low_bcd     = to_packed_bcd(jy % 100);
        r.jmonth_bcd        = to_packed_bcd(k + 1);
        r.jday_bcd          = to_packed_bcd((days + 1) % 100);
        return r;
    endfunction

    // Called right after a rising edge; returns at the edge that accepts the transaction.
    task automatic offer_date(input logic [7:0] y, input logic [7:0] m, input logic [7:0] d);
        t_in_item item;
        item = {y, m, d};
        if (!steady_phase && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        jalali_due.push_back(jalali_of(item));
    endtask

    always @(posedge i_clk) begin
        if (steady_phase)
            i_out_ready <= 1'b1;
        else
            i_out_ready <= ($urandom_range(99) >= 11);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (jalali_due.size() == 0) begin
                $error("unexpected result transaction %h", o_out_item);
                mismatches++;
            end else begin
                want = jalali_due.pop_front();
                if (o_out_item.jyear_century_bcd !== want.jyear_century_bcd) begin
                    $error("jyear_century_bcd: expected %h, actual %h",
                           want.jyear_century_bcd, o_out_item.jyear_century_bcd);
                    mismatches++;
                end
                if (o_out_item.jyear_low_bcd !== want.jyear_low_bcd) begin
                    $error("jyear_low_bcd: expected %h, actual %h",
                           want.jyear_low_bcd, o_out_item.jyear_low_bcd);
                    mismatches++;
                end
                if (o_out_item.jmonth_bcd !== want.jmonth_bcd) begin
                    $error("jmonth_bcd: expected %h, actual %h",
                           want.jmonth_bcd, o_out_item.jmonth_bcd);
                    mismatches++;
                end
                if (o_out_item.jday_bcd !== want.jday_bcd) begin
                    $error("jday_bcd: expected %h, actual %h",
                           want.jday_bcd, o_out_item.jday_bcd);
                    mismatches++;
                end
                if (o_out_item.bad_input !== want.bad_input) begin
                    $error("bad_input: expected %b, actual %b",
                           want.bad_input, o_out_item.bad_input);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_count <= 0;
            else if (quiet_count + 1 >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else
                quiet_count <= quiet_count + 1;
        end
    end

    task automatic test_calendar_edges();
        offer_date(8'h00, 8'h01, 8'h01);
        offer_date(8'h99, 8'h12, 8'h31);
        offer_date(8'h00, 8'h02, 8'h29);
        offer_date(8'h04, 8'h02, 8'h29);
        offer_date(8'h01, 8'h03, 8'h01);
        // Days around Nowruz, where the Jalali year rolls over.
        offer_date(8'h24, 8'h03, 8'h19);
        offer_date(8'h24, 8'h03, 8'h20);
        offer_date(8'h25, 8'h03, 8'h21);
        offer_date(8'h99, 8'h03, 8'h20);
        offer_date(8'h23, 8'h03, 8'h20);
        offer_date(8'h77, 8'h09, 8'h30);
    endtask

    task automatic test_rejected_dates();
        offer_date(8'hFF, 8'h01, 8'h01);
        offer_date(8'h0A, 8'h06, 8'h15);
        offer_date(8'hA0, 8'h06, 8'h15);
        offer_date(8'h10, 8'h1A, 8'h01);
        offer_date(8'h10, 8'h00, 8'h10);
        offer_date(8'h10, 8'h13, 8'h10);
        offer_date(8'h10, 8'h99, 8'h10);
        offer_date(8'h10, 8'h05, 8'h00);
        offer_date(8'h10, 8'h05, 8'h32);
        offer_date(8'h10, 8'h04, 8'h31);
        offer_date(8'h01, 8'h02, 8'h29);
        offer_date(8'h00, 8'h02, 8'h30);
        offer_date(8'h10, 8'h05, 8'hF9);
        offer_date(8'h10, 8'h05, 8'h9F);
    endtask

    task automatic test_random_dates();
        int unsigned n, yy, mm, dd, kind, mlen, pick;
        logic [7:0]  yb, mb, db;
        for (n = 0; n < RANDOM_DATES; n++) begin
            steady_phase = (n >= 500 && n < 800);
            yy   = $urandom_range(99);
            mm   = $urandom_range(12, 1);
            mlen = greg_month_len(mm, leap_20yy(yy));
            dd   = $urandom_range(mlen, 1);
            yb   = to_packed_bcd(yy);
            mb   = to_packed_bcd(mm);
            db   = to_packed_bcd(dd);
            kind = $urandom_range(99);
            if (kind >= 95) begin
                yb = 8'($urandom);
                mb = 8'($urandom);
                db = 8'($urandom);
            end else if (kind >= 90) begin
                // One digit pushed out of the BCD range.
                pick = $urandom_range(5);
                unique case (pick)
                    0: yb[7:4] = 4'($urandom_range(15, 10));
                    1: yb[3:0] = 4'($urandom_range(15, 10));
                    2: mb[7:4] = 4'($urandom_range(15, 10));
                    3: mb[3:0] = 4'($urandom_range(15, 10));
                    4: db[7:4] = 4'($urandom_range(15, 10));
                    default: db[3:0] = 4'($urandom_range(15, 10));
                endcase
            end else if (kind >= 87) begin
                mb = ($urandom_range(1) == 0) ? 8'h00 : to_packed_bcd($urandom_range(99, 13));
            end else if (kind >= 84) begin
                db = ($urandom_range(1) == 0) ? 8'h00 : to_packed_bcd($urandom_range(99, mlen + 1));
            end
            offer_date(yb, mb, db);
        end
        steady_phase = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_calendar_edges();
        test_rejected_dates();
        test_random_dates();
        i_in_valid <= 1'b0;
        while (jalali_due.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
